// ===== hw/rtl/tza_pkg.sv =====
// Package for the time zone date adjust block: stamp type, calendar constants
// and the month length and leap year helpers. No dependencies.
package tza_pkg;

  localparam int unsigned YearW   = 14;
  localparam int unsigned MonthW  = 4;
  localparam int unsigned DayW    = 5;
  localparam int unsigned WdayW   = 3;
  localparam int unsigned HourW   = 5;
  localparam int unsigned MinuteW = 6;
  localparam int unsigned SecondW = 6;
  localparam int unsigned OffsetW = 5;
  localparam int unsigned DataW   = 48;

  localparam logic [6:0]        HoursPerDay   = 7'd24;
  localparam logic [WdayW-1:0]  LastWeekday   = 3'd6;
  localparam logic [WdayW-1:0]  BadWeekday    = 3'd7;
  localparam logic [MonthW-1:0] MonthsPerYear = 4'd12;
  localparam logic [MonthW-1:0] February      = 4'd2;

  // y is a multiple of 25 iff y * inv(25) mod 2^14 <= floor((2^14 - 1) / 25)
  localparam logic [YearW-1:0] YearInv25    = 14'd7209;
  localparam logic [YearW-1:0] YearDiv25Max = 14'd655;

  typedef struct packed {
    logic [YearW-1:0]   year;
    logic [MonthW-1:0]  month;
    logic [DayW-1:0]    day;
    logic [WdayW-1:0]   weekday;
    logic [HourW-1:0]   hour;
    logic [MinuteW-1:0] minute;
    logic [SecondW-1:0] second;
  } stamp_t;

  function automatic logic is_leap(logic [YearW-1:0] year);
    logic [YearW-1:0] prod;
    logic             div25;
    prod  = year * YearInv25;
    div25 = (prod <= YearDiv25Max);
    return (year[1:0] == 2'b00) && (!div25 || (year[3:0] == 4'b0000));
  endfunction

  // Months outside 1..12 count as 31 days
  function automatic logic [DayW-1:0] days_in(logic [MonthW-1:0] month, logic leap);
    logic [DayW-1:0] len;
    case (month)
      February: len = leap ? 5'd29 : 5'd28;
      4'd4:     len = 5'd30;
      4'd6:     len = 5'd30;
      4'd9:     len = 5'd30;
      4'd11:    len = 5'd30;
      default:  len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// ===== hw/rtl/timezone_date_adjust_core.sv =====
// Top level of the time zone date adjust block: input register, date math
// (tza_calc) and output register. Uses tza_pkg.
//
// Usage: write the signed hour offset (-12..14) through cfg_we_i/cfg_wdata_i
// while the block is idle; it resets to 0 (UTC). Each slave-side transfer
// carries one UTC stamp; each master-side transfer returns the local stamp.
// Minute and second are copied through.
// Pipeline: two register stages, an input register and a result register;
// an accepted stamp passes through both before it shows on m_axis_tvalid.
// Throughput: one stamp per cycle while m_axis_tready is high, set by the
// single pass of date logic between the two registers.
// Stall: while m_axis_tready is low the result holds; one more stamp is
// taken only if the input register is empty, then s_axis_tready drops.
// Reset: both stages empty, the offset register cleared to zero.
module timezone_date_adjust_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [tza_pkg::OffsetW-1:0]        cfg_wdata_i,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // year[13:0] month[17:14] day[22:18] weekday[25:23] hour[30:26]
  // minute[36:31] second[42:37], zero above
  input  logic [tza_pkg::DataW-1:0]          s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // year[13:0] month[17:14] day[22:18] weekday[25:23] hour[30:26]
  // minute[36:31] second[42:37], zero above
  output logic [tza_pkg::DataW-1:0]          m_axis_tdata
);
  import tza_pkg::*;

  logic [OffsetW-1:0] zone_q;
  logic               in_valid_q;
  logic               out_valid_q;
  stamp_t             in_q;
  stamp_t             out_q;
  stamp_t             in_stamp;
  stamp_t             calc_stamp;
  logic               out_free;
  logic               in_free;

  assign in_stamp.year    = s_axis_tdata[13:0];
  assign in_stamp.month   = s_axis_tdata[17:14];
  assign in_stamp.day     = s_axis_tdata[22:18];
  assign in_stamp.weekday = s_axis_tdata[25:23];
  assign in_stamp.hour    = s_axis_tdata[30:26];
  assign in_stamp.minute  = s_axis_tdata[36:31];
  assign in_stamp.second  = s_axis_tdata[42:37];

  assign out_free      = !out_valid_q || m_axis_tready;
  assign in_free       = !in_valid_q || out_free;
  assign s_axis_tready = in_free;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b00000, out_q.second, out_q.minute, out_q.hour,
                          out_q.weekday, out_q.day, out_q.month, out_q.year};

  tza_calc u_calc (
    .stamp_i  (in_q),
    .offset_i (signed'(zone_q)),
    .stamp_o  (calc_stamp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zone_q      <= '0;
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        zone_q <= cfg_wdata_i;
      end
      if (in_free) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (out_free) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  // Payload: load on transfer or advance, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_free && s_axis_tvalid) begin
      in_q <= in_stamp;
    end
    if (out_free && in_valid_q) begin
      out_q <= calc_stamp;
    end
  end

  a_stage_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !out_valid_q) |=> out_valid_q)
    else $error("input stage did not advance into empty result register");

  a_hour_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (out_q.hour < 5'd24))
    else $error("local hour out of range");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (in_valid_q && out_valid_q))
    else $error("input stalled while a stage is free");

endmodule

// ===== hw/rtl/tza_calc.sv =====
// Combinational date math: adds the zone offset to the hour and carries or
// borrows one day through weekday, day, month and year. Uses tza_pkg.
module tza_calc (
  input  tza_pkg::stamp_t                     stamp_i,
  input  logic signed [tza_pkg::OffsetW-1:0]  offset_i,
  output tza_pkg::stamp_t                     stamp_o
);
  import tza_pkg::*;

  logic [6:0]        hour_sum;
  logic              borrow;
  logic              carry;
  logic              leap;
  logic [DayW-1:0]   len_cur;
  logic [MonthW-1:0] prev_month;
  logic [DayW-1:0]   len_prev;
  logic [DayW:0]     day_inc;

  assign hour_sum = {2'b00, stamp_i.hour} + {{2{offset_i[OffsetW-1]}}, offset_i};
  assign borrow   = hour_sum[6];
  assign carry    = !hour_sum[6] && (hour_sum >= HoursPerDay);

  assign leap       = is_leap(stamp_i.year);
  assign len_cur    = days_in(stamp_i.month, leap);
  // Month 0 or 1 steps back to 11 or 12 of the year before; February only
  // appears here without a year change, so the current year's leap flag holds
  assign prev_month = (stamp_i.month <= 4'd1) ? stamp_i.month + 4'd11 : stamp_i.month - 4'd1;
  assign len_prev   = days_in(prev_month, leap);
  assign day_inc    = {1'b0, stamp_i.day} + 6'd1;

  always_comb begin
    stamp_o      = stamp_i;
    stamp_o.hour = hour_sum[HourW-1:0];
    if (borrow) begin
      stamp_o.hour    = 5'(hour_sum + HoursPerDay);
      stamp_o.weekday = (stamp_i.weekday == 3'd0) ? LastWeekday : stamp_i.weekday - 3'd1;
      if (stamp_i.day <= 5'd1) begin
        stamp_o.month = prev_month;
        stamp_o.day   = stamp_i.day + len_prev - 5'd1;
        if (stamp_i.month <= 4'd1) begin
          stamp_o.year = stamp_i.year - 14'd1;
        end
      end else begin
        stamp_o.day = stamp_i.day - 5'd1;
      end
    end else if (carry) begin
      stamp_o.hour = 5'(hour_sum - HoursPerDay);
      case (stamp_i.weekday)
        LastWeekday: stamp_o.weekday = 3'd0;
        BadWeekday:  stamp_o.weekday = 3'd1;
        default:     stamp_o.weekday = stamp_i.weekday + 3'd1;
      endcase
      if (day_inc > {1'b0, len_cur}) begin
        stamp_o.day = 5'd1;
        if (stamp_i.month >= MonthsPerYear) begin
          stamp_o.month = stamp_i.month - 4'd11;
          stamp_o.year  = stamp_i.year + 14'd1;
        end else begin
          stamp_o.month = stamp_i.month + 4'd1;
        end
      end else begin
        stamp_o.day = day_inc[DayW-1:0];
      end
    end
  end

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for timezone_date_adjust_core: UTC stamps in, local stamps out,
// each checked against a typed value or a calendar predictor here. Depends on tza_pkg.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import tza_pkg::*;

  localparam int WatchdogLimit = 2000;
  localparam int PhaseItems    = 200;
  localparam int NumPhases     = 10;
  localparam int DirRows       = 23;

  typedef struct {
    int     offset;
    stamp_t utc;
    bit     typed;
    stamp_t want;
  } dir_row_t;

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               cfg_we_i      = 1'b0;
  logic [OffsetW-1:0] cfg_wdata_i   = '0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  // year, month, day, weekday, hour, minute, second from bit 0 up, zero above
  logic [DataW-1:0]   s_axis_tdata  = '0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  // year, month, day, weekday, hour, minute, second from bit 0 up, zero above
  logic [DataW-1:0]   m_axis_tdata;

  logic signed [OffsetW-1:0] zone_offset = '0;
  stamp_t                    pending_local[$];
  int                        mismatch_count = 0;
  int                        idle_cycles = 0;
  bit                        quiet = 1'b0;
  bit                        hold_req = 1'b0;

  timezone_date_adjust_core u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic stamp_t make_stamp(int y, int mo, int d, int w, int h, int mi, int s);
    stamp_t st;
    st.year    = YearW'(y);
    st.month   = MonthW'(mo);
    st.day     = DayW'(d);
    st.weekday = WdayW'(w);
    st.hour    = HourW'(h);
    st.minute  = MinuteW'(mi);
    st.second  = SecondW'(s);
    return st;
  endfunction

  function automatic logic [DataW-1:0] to_bus(stamp_t st);
    return {5'b0, st.second, st.minute, st.hour, st.weekday, st.day, st.month, st.year};
  endfunction

  function automatic stamp_t from_bus(logic [DataW-1:0] bus);
    return make_stamp(int'(bus[13:0]), int'(bus[17:14]), int'(bus[22:18]), int'(bus[25:23]),
                      int'(bus[30:26]), int'(bus[36:31]), int'(bus[42:37]));
  endfunction

  function automatic bit leap_year(int yr);
    if (yr % 400 == 0) return 1'b1;
    if (yr % 100 == 0) return 1'b0;
    return (yr % 4 == 0);
  endfunction

  // Months outside 1..12 are 31 days long
  function automatic int month_days(int mo, int yr);
    if (mo < 1 || mo > 12) return 31;
    case (mo)
      2:             return leap_year(yr) ? 29 : 28;
      4, 6, 9, 11:   return 30;
      default:       return 31;
    endcase
  endfunction

  function automatic stamp_t shift_to_local(stamp_t utc, logic signed [OffsetW-1:0] offset);
    int yr;
    int mo;
    int d;
    int w;
    int h;
    yr = int'(utc.year);
    mo = int'(utc.month);
    d  = int'(utc.day);
    w  = int'(utc.weekday);
    h  = int'(utc.hour) + int'(offset);
    if (h < 0) begin
      // borrow one day; the new month length is taken after the year steps back
      w = (w == 0) ? 6 : w - 1;
      d = d - 1;
      if (d <= 0) begin
        mo = mo - 1;
        if (mo <= 0) begin
          yr = (yr + 16383) % 16384;
          mo = mo + 12;
        end
        d = d + month_days(mo, yr);
      end
      h = h + 24;
    end else if (h >= 24) begin
      w = w + 1;
      if (w >= 7) w = w - 7;
      d = d + 1;
      if (d > month_days(mo, yr)) begin
        mo = mo + 1;
        if (mo > 12) begin
          yr = (yr + 1) % 16384;
          mo = mo - 12;
        end
        d = 1;
      end
      h = h - 24;
    end
    return make_stamp(yr, mo, d, w, h, int'(utc.minute), int'(utc.second));
  endfunction

  // Mostly valid dates near month ends and day boundaries, some raw noise
  function automatic stamp_t random_stamp();
    int yr;
    int mo;
    int len;
    int d;
    int h;
    if ($urandom_range(0, 7) == 0)
      return make_stamp($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    case ($urandom_range(0, 9))
      0:       yr = 0;
      1:       yr = 16383;
      2:       yr = 100 * $urandom_range(0, 99);
      3:       yr = 4 * $urandom_range(0, 4095);
      default: yr = $urandom_range(0, 9999);
    endcase
    mo  = $urandom_range(1, 12);
    len = month_days(mo, yr);
    case ($urandom_range(0, 4))
      0:       d = 1;
      1:       d = len;
      2:       d = len - 1;
      default: d = $urandom_range(1, len);
    endcase
    if ($urandom_range(0, 1) == 0) begin
      h = $urandom_range(0, 23);
    end else begin
      h = (zone_offset >= 0) ? 24 - int'(zone_offset) : -int'(zone_offset);
      h = h + int'($urandom_range(0, 3)) - 2;
      if (h < 0) h = 0;
      if (h > 23) h = 23;
    end
    return make_stamp(yr, mo, d, $urandom_range(0, 6), h, $urandom_range(0, 59),
                      $urandom_range(0, 60));
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  task automatic compare_local(input stamp_t got, input stamp_t want);
    if (got.year != want.year)
      report_mismatch("year", int'(got.year), int'(want.year));
    if (got.month != want.month)
      report_mismatch("month", int'(got.month), int'(want.month));
    if (got.day != want.day)
      report_mismatch("day", int'(got.day), int'(want.day));
    if (got.weekday != want.weekday)
      report_mismatch("weekday", int'(got.weekday), int'(want.weekday));
    if (got.hour != want.hour)
      report_mismatch("hour", int'(got.hour), int'(want.hour));
    if (got.minute != want.minute)
      report_mismatch("minute", int'(got.minute), int'(want.minute));
    if (got.second != want.second)
      report_mismatch("second", int'(got.second), int'(want.second));
  endtask

  // Hold the stamp until the block takes it, then record what it should return
  task automatic offer_stamp(input stamp_t utc, input stamp_t want);
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = to_bus(utc);
    do @(posedge clk_i); while (!s_axis_tready);
    pending_local.push_back(want);
  endtask

  // Drain the pipeline, then change the zone offset
  task automatic write_offset(input int value);
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (pending_local.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = OffsetW'(value);
    zone_offset = OffsetW'(value);
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_local.size() == 0)
        report_mismatch("result with nothing pending", int'(m_axis_tdata[31:0]), 0);
      else
        compare_local(from_bus(m_axis_tdata), pending_local.pop_front());
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // Receiver: random stall bursts, one long hold-off on request
  initial begin
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        m_axis_tready = 1'b0;
        hold_req      = 1'b0;
        repeat (63) @(negedge clk_i);
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        m_axis_tready = 1'b0;
        repeat ($urandom_range(1, 9) - 1) @(negedge clk_i);
      end else begin
        m_axis_tready = 1'b1;
        repeat ($urandom_range(0, 7)) @(negedge clk_i);
      end
    end
  end

  initial begin
    dir_row_t dir_rows[DirRows];
    int       phase_offsets[NumPhases];
    int       value;
    stamp_t   utc;

    dir_rows = '{
      // zero offset: stamps pass through, out-of-range fields included
      '{0, make_stamp(2024, 6, 15, 3, 12, 30, 45), 1'b1, make_stamp(2024, 6, 15, 3, 12, 30, 45)},
      '{0, make_stamp(0, 1, 1, 0, 0, 0, 0), 1'b1, make_stamp(0, 1, 1, 0, 0, 0, 0)},
      '{0, make_stamp(16383, 15, 31, 7, 23, 63, 63), 1'b1,
        make_stamp(16383, 15, 31, 7, 23, 63, 63)},
      // carry: new year, leap and common February, year wrap, bad month/weekday/hour/day
      '{14, make_stamp(2023, 12, 31, 0, 10, 59, 60), 1'b1, make_stamp(2024, 1, 1, 1, 0, 59, 60)},
      '{14, make_stamp(2024, 2, 28, 3, 12, 1, 2), 1'b1, make_stamp(2024, 2, 29, 4, 2, 1, 2)},
      '{14, make_stamp(2023, 2, 28, 2, 12, 3, 4), 1'b0, '0},
      '{14, make_stamp(1900, 2, 28, 3, 15, 5, 6), 1'b0, '0},
      '{14, make_stamp(2000, 2, 28, 1, 20, 7, 8), 1'b0, '0},
      '{14, make_stamp(16383, 12, 31, 6, 23, 9, 10), 1'b1, make_stamp(0, 1, 1, 0, 13, 9, 10)},
      '{14, make_stamp(2020, 15, 31, 7, 20, 11, 12), 1'b0, '0},
      '{14, make_stamp(2020, 5, 10, 2, 31, 13, 14), 1'b0, '0},
      '{14, make_stamp(2020, 4, 0, 2, 20, 15, 16), 1'b0, '0},
      // borrow: year start, leap Feb, year wrap, bad weekday/month, day zero, mid-month
      '{-12, make_stamp(2024, 1, 1, 1, 0, 0, 0), 1'b1, make_stamp(2023, 12, 31, 0, 12, 0, 0)},
      '{-12, make_stamp(2024, 3, 1, 5, 5, 17, 18), 1'b0, '0},
      '{-12, make_stamp(0, 1, 1, 0, 3, 19, 20), 1'b1, make_stamp(16383, 12, 31, 6, 15, 19, 20)},
      '{-12, make_stamp(2021, 6, 10, 7, 1, 21, 22), 1'b0, '0},
      '{-12, make_stamp(2021, 0, 1, 3, 2, 23, 24), 1'b0, '0},
      '{-12, make_stamp(2021, 13, 1, 2, 4, 25, 26), 1'b0, '0},
      '{-12, make_stamp(2021, 5, 0, 1, 0, 27, 28), 1'b0, '0},
      '{-12, make_stamp(2021, 3, 15, 1, 11, 29, 30), 1'b0, '0},
      // widest offsets the register can hold
      '{15, make_stamp(2021, 7, 31, 6, 31, 31, 32), 1'b0, '0},
      '{-16, make_stamp(2021, 3, 1, 0, 0, 33, 34), 1'b0, '0},
      '{-16, make_stamp(2021, 3, 1, 0, 16, 35, 36), 1'b0, '0}
    };
    phase_offsets = '{14, -12, 5, -16, 15, -3, 11, -9, 0, 1};

    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].offset != int'(zone_offset)) write_offset(dir_rows[i].offset);
      offer_stamp(dir_rows[i].utc, dir_rows[i].typed ? dir_rows[i].want :
                  shift_to_local(dir_rows[i].utc, zone_offset));
    end

    for (int ph = 0; ph < NumPhases; ph++) begin
      value = (ph == 8) ? int'($urandom_range(0, 31)) - 16 : phase_offsets[ph];
      write_offset(value);
      quiet = (ph == 5 || ph == NumPhases - 1);
      for (int i = 0; i < PhaseItems; i++) begin
        // long receiver hold-off while stamps keep coming
        if (ph == 2 && i == 60) hold_req = 1'b1;
        if (!quiet && $urandom_range(0, 5) == 0) begin
          @(negedge clk_i);
          s_axis_tvalid = 1'b0;
          repeat ($urandom_range(1, 9) - 1) @(negedge clk_i);
        end
        utc = random_stamp();
        offer_stamp(utc, shift_to_local(utc, zone_offset));
      end
    end

    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (pending_local.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
